/* hw/rtl/sha1_pkg.sv */
// Shared types and constants for the SHA-1 hash engine.
// Used by the compression unit and the top level; depends on nothing.
`default_nettype none

package sha1_pkg;

  localparam int unsigned NumWords = 5;
  localparam int unsigned WinDepth = 16;
  localparam int unsigned WinAw    = $clog2(WinDepth);

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [NumWords-1:0][31:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] FILL_MAX   = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_IDX   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    T_IDLE, T_PAD, T_CGO, T_CWAIT, T_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    P_80, P_ZERO, P_LEN
  } pad_phase_e;

  typedef enum logic [1:0] {
    R_IDLE, R_PAD, R_EMIT
  } resume_e;

  typedef enum logic [1:0] {
    C_IDLE, C_EXE, C_RD1, C_FIN
  } cmp_state_e;

  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

  typedef struct packed {
    logic             we;
    logic [WinAw-1:0] addr;
    logic [31:0]      data;
  } ram_wr_t;

endpackage

`default_nettype wire

/* hw/rtl/sha1_hash_engine_core.sv */
// SHA-1 byte-stream engine. A byte request is taken while the engine is idle; each full 64-byte
// block stalls input while it is compressed: a start, rounds 0-15 with one read each, rounds
// 16-79 with a C_RD1 read step before each round on the dual-read schedule RAM, and a finish.
// A last request adds padding, one or two block passes, then five digest words.
// Reset is asynchronous: control and chaining words clear at once, no clearing pass.
`default_nettype none

module sha1_hash_engine_core
  import sha1_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire in_item_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_data_o
);

  top_state_e state_q, state_d;
  pad_phase_e phase_q, phase_d;
  resume_e    resume_q, resume_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [31:0] word_q, word_d;
  logic [2:0]  emit_idx_q, emit_idx_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q;

  logic        in_acc, out_free, out_load, push;
  logic [7:0]  push_byte;
  ram_wr_t     ld_wr, cmp_wr, ram_wr;
  cmp_ctrl_t   cmp_ctrl;
  cmp_stat_t   cmp_stat;
  logic [WinAw-1:0] rd_addr_a, rd_addr_b;
  logic [31:0] rd_data_a, rd_data_b, emit_word;

  assign in_stall_o = (state_q != T_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    resume_d   = resume_q;
    len_d      = len_q;
    emit_idx_d = emit_idx_q;
    cmp_ctrl   = '0;
    out_load   = 1'b0;
    push       = 1'b0;
    push_byte  = '0;

    unique case (state_q)
      T_IDLE: begin
        if (in_acc) begin
          if (in_data_i.has_byte) begin
            push      = 1'b1;
            push_byte = in_data_i.data_byte;
            len_d     = len_q + 64'd8;
          end
          if (in_data_i.last) begin
            phase_d = P_80;
          end
          if (in_data_i.has_byte && (fill_q == FILL_MAX)) begin
            state_d  = T_CGO;
            resume_d = in_data_i.last ? R_PAD : R_IDLE;
          end else if (in_data_i.last) begin
            state_d = T_PAD;
          end
        end
      end
      T_PAD: begin
        unique case (phase_q)
          P_80: begin
            push      = 1'b1;
            push_byte = PAD_BYTE;
            phase_d   = P_ZERO;
          end
          P_ZERO: begin
            if (fill_q != LEN_POS) begin
              push = 1'b1;
            end else begin
              phase_d = P_LEN;
            end
          end
          P_LEN: begin
            push      = 1'b1;
            push_byte = len_q[63:56];
            len_d     = {len_q[55:0], 8'h00};
          end
          default: begin
            phase_d = P_80;
          end
        endcase
        // A full block goes through the compression unit; the length bytes end
        // the message, anything else resumes padding afterwards.
        if (push && (fill_q == FILL_MAX)) begin
          state_d  = T_CGO;
          resume_d = (phase_q == P_LEN) ? R_EMIT : R_PAD;
        end
      end
      T_CGO: begin
        cmp_ctrl.start = 1'b1;
        state_d        = T_CWAIT;
      end
      T_CWAIT: begin
        if (cmp_stat.done) begin
          emit_idx_d = '0;
          unique case (resume_q)
            R_IDLE:  state_d = T_IDLE;
            R_PAD:   state_d = T_PAD;
            R_EMIT:  state_d = T_EMIT;
            default: state_d = T_IDLE;
          endcase
        end
      end
      T_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (emit_idx_q == LAST_IDX) begin
            cmp_ctrl.init = 1'b1;
            len_d         = '0;
            state_d       = T_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  // Bytes are packed big-endian into words; every fourth byte writes a word.
  always_comb begin
    word_d = word_q;
    fill_d = fill_q;
    ld_wr  = '0;
    if (push) begin
      word_d = {word_q[23:0], push_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q[1:0] == 2'b11) begin
        ld_wr.we   = 1'b1;
        ld_wr.addr = fill_q[5:2];
        ld_wr.data = word_d;
      end
    end
  end

  assign ram_wr      = ld_wr.we ? ld_wr : cmp_wr;
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      phase_q     <= P_80;
      resume_q    <= R_IDLE;
      fill_q      <= '0;
      len_q       <= '0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      resume_q    <= resume_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    if (out_load) begin
      out_q.digest_word <= emit_word;
      out_q.word_index  <= emit_idx_q;
      out_q.last_word   <= (emit_idx_q == LAST_IDX);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Two mirrored copies of the schedule window give two reads per cycle.
  sha1_ram #(
    .W(32),
    .D(WinDepth)
  ) u_win_a (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (rd_addr_a),
    .rdata_o (rd_data_a)
  );

  sha1_ram #(
    .W(32),
    .D(WinDepth)
  ) u_win_b (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (rd_addr_b),
    .rdata_o (rd_data_b)
  );

  sha1_compress u_compress (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (cmp_ctrl),
    .stat_o      (cmp_stat),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .wr_o        (cmp_wr),
    .emit_idx_i  (emit_idx_q),
    .emit_word_o (emit_word)
  );

`ifndef SYNTHESIS
  a_one_writer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ld_wr.we && cmp_wr.we))
    else $error("loader and compression unit write the window together");

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_ctrl.start |-> !cmp_stat.busy)
    else $error("compression started while a block is in progress");

  a_emit_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_EMIT) |-> (fill_q == '0))
    else $error("digest emitted with bytes left in the block buffer");

  a_emit_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_EMIT && out_load && emit_idx_q == LAST_IDX)
      |=> (state_q == T_IDLE) && (len_q == '0))
    else $error("engine did not return to its start state after the digest");
`endif

endmodule

`default_nettype wire

/* hw/rtl/sha1_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
`default_nettype none

module sha1_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output      logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/sha1_compress.sv */
// SHA-1 compression unit: round sequencer, working variables and chaining words.
// Reads and rewrites the 16-word schedule window held in RAM; uses sha1_pkg.
`default_nettype none

module sha1_compress
  import sha1_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmp_ctrl_t        ctrl_i,
  output      cmp_stat_t        stat_o,
  output      logic [WinAw-1:0] rd_addr_a_o,
  output      logic [WinAw-1:0] rd_addr_b_o,
  input  wire logic [31:0]      rd_data_a_i,
  input  wire logic [31:0]      rd_data_b_i,
  output      ram_wr_t          wr_o,
  input  wire logic [2:0]       emit_idx_i,
  output      logic [31:0]      emit_word_o
);

  cmp_state_e state_q, state_d;
  logic [6:0] t_q, t_d;
  logic [6:0] t_next;
  logic [WinAw-1:0] tn_lo;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [31:0] x_q, x_d;
  logic [NumWords-1:0][31:0] h_q, h_d;
  logic [31:0] w, f, k, tmp, x3;

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    x_d         = x_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    e_d         = e_q;
    h_d         = h_q;
    rd_addr_a_o = '0;
    rd_addr_b_o = '0;
    wr_o        = '0;
    stat_o      = '0;
    stat_o.busy = (state_q != C_IDLE);
    t_next      = t_q + 7'd1;
    tn_lo       = t_next[WinAw-1:0];

    x3  = x_q ^ rd_data_a_i ^ rd_data_b_i;
    w   = (t_q < 7'd16) ? rd_data_a_i : {x3[30:0], x3[31]};
    if (t_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (t_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (t_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + k + w;

    unique case (state_q)
      C_IDLE: begin
        // Address zero is presented here, so word 0 arrives with the first round.
        if (ctrl_i.start) begin
          a_d     = h_q[0];
          b_d     = h_q[1];
          c_d     = h_q[2];
          d_d     = h_q[3];
          e_d     = h_q[4];
          t_d     = '0;
          state_d = C_EXE;
        end
        if (ctrl_i.init) begin
          h_d = H_INIT;
        end
      end
      C_EXE: begin
        if (t_q >= 7'd16) begin
          wr_o.we   = 1'b1;
          wr_o.addr = t_q[WinAw-1:0];
          wr_o.data = w;
        end
        e_d = d_q;
        d_d = c_q;
        c_d = {b_q[1:0], b_q[31:2]};
        b_d = a_q;
        a_d = tmp;
        // The reads for the next round are issued here. None of them hits the
        // entry written in this cycle, so no forwarding is needed.
        if (t_q == LAST_ROUND) begin
          state_d = C_FIN;
        end else begin
          t_d = t_next;
          if (t_next < 7'd16) begin
            rd_addr_a_o = tn_lo;
            state_d     = C_EXE;
          end else begin
            rd_addr_a_o = tn_lo + 4'd13;
            rd_addr_b_o = tn_lo + 4'd8;
            state_d     = C_RD1;
          end
        end
      end
      C_RD1: begin
        x_d         = rd_data_a_i ^ rd_data_b_i;
        rd_addr_a_o = t_q[WinAw-1:0] + 4'd2;
        rd_addr_b_o = t_q[WinAw-1:0];
        state_d     = C_EXE;
      end
      C_FIN: begin
        h_d[0]      = h_q[0] + a_q;
        h_d[1]      = h_q[1] + b_q;
        h_d[2]      = h_q[2] + c_q;
        h_d[3]      = h_q[3] + d_q;
        h_d[4]      = h_q[4] + e_q;
        stat_o.done = 1'b1;
        state_d     = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  assign emit_word_o = (emit_idx_i <= LAST_IDX) ? h_q[emit_idx_i] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      t_q     <= '0;
      h_q     <= H_INIT;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    e_q <= e_d;
    x_q <= x_d;
  end

`ifndef SYNTHESIS
  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> (wr_o.addr != rd_addr_a_o) && (wr_o.addr != rd_addr_b_o))
    else $error("schedule write collides with a read in the same cycle");

  a_fin_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_FIN) |-> ($past(state_q) == C_EXE) && ($past(t_q) == LAST_ROUND))
    else $error("block finished without completing the last round");

  a_rd1_expanded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_RD1) |-> (t_q >= 7'd16) && (t_q <= LAST_ROUND))
    else $error("schedule expansion step outside the expanded rounds");
`endif

endmodule

`default_nettype wire

/* verif/tb_sha1_hash_engine_core.sv */
// Self-checking testbench for the SHA-1 byte-stream engine: drives byte requests,
// predicts each 160-bit digest in a scoreboard class and checks every digest word.
// Depends on sha1_pkg and sha1_hash_engine_core.

module tb_sha1_hash_engine_core;
  import sha1_pkg::*;

  localparam int unsigned WatchLimit = 5000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned RandomItems = 130;

  class sha1_digest_predictor;
    logic [31:0] chain [NumWords];
    logic [7:0]  blk [64];
    logic [63:0] msg_bits;
    int unsigned held;
    out_item_t   digest_words_due [$];
    int unsigned errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < NumWords; i++) chain[i] = H_INIT[i];
      msg_bits = '0;
      held = 0;
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, x, tmp;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 16) begin
          w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        end else begin
          x = w[(t+13)%16] ^ w[(t+8)%16] ^ w[(t+2)%16] ^ w[t%16];
          w[t%16] = {x[30:0], x[31]};
        end
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = K0;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = K1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end else begin
          f = b ^ c ^ d;
          k = K3;
        end
        tmp = {a[26:0], a[31:27]} + f + e + k + w[t%16];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = tmp;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    // Takes one accepted request; a last request closes the message and queues its digest.
    function void absorb_request(in_item_t req);
      out_item_t word;
      if (req.has_byte) begin
        blk[held] = req.data_byte;
        held++;
        msg_bits += 64'd8;
        if (held == 64) begin
          compress();
          held = 0;
        end
      end
      if (!req.last) return;
      blk[held] = PAD_BYTE;
      held++;
      // No room left for the length field, so padding spills into a second block.
      if (held > LEN_POS) begin
        while (held < 64) begin
          blk[held] = 8'h00;
          held++;
        end
        compress();
        held = 0;
      end
      while (held < LEN_POS) begin
        blk[held] = 8'h00;
        held++;
      end
      for (int i = 0; i < 8; i++) blk[LEN_POS+i] = msg_bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < NumWords; i++) begin
        word.digest_word = chain[i];
        word.word_index  = 3'(i);
        word.last_word   = (3'(i) == LAST_IDX);
        digest_words_due.push_back(word);
      end
      restart();
    endfunction

    function void check_digest_word(out_item_t got);
      out_item_t want;
      if (digest_words_due.size() == 0) begin
        $error("digest word %h arrived with no digest pending", got.digest_word);
        errors++;
        return;
      end
      want = digest_words_due.pop_front();
      if (got.digest_word !== want.digest_word) begin
        $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  sha1_digest_predictor sb = new();

  bit          idle_on = 1'b1;
  bit          noise_on = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned msg_items = 0;
  int unsigned msg_count = 0;

  sha1_hash_engine_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Entered and left at a falling edge; valid stays high between back-to-back requests.
  task automatic send_request(input in_item_t req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.absorb_request(req);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned len, input bit last_alone);
    in_item_t req;
    for (int unsigned i = 0; i < len; i++) begin
      if (noise_on && $urandom_range(0, 9) == 0) begin
        req.data_byte = 8'($urandom_range(0, 255));
        req.has_byte  = 1'b0;
        req.last      = 1'b0;
        send_request(req);
      end
      req.data_byte = 8'($urandom_range(0, 255));
      req.has_byte  = 1'b1;
      req.last      = (i == len - 1) && !last_alone;
      send_request(req);
      msg_items++;
    end
    if (last_alone || len == 0) begin
      req.data_byte = 8'($urandom_range(0, 255));
      req.has_byte  = 1'b0;
      req.last      = 1'b1;
      send_request(req);
      msg_items++;
    end
    msg_count++;
  endtask

  task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
    in_item_t req;
    req.has_byte  = 1'b1;
    req.last      = 1'b0;
    req.data_byte = b0;
    send_request(req);
    req.data_byte = b1;
    send_request(req);
    req.data_byte = b2;
    req.last      = 1'b1;
    send_request(req);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    int unsigned burst_left;
    hold_left   = 0;
    burst_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst_left  = $urandom_range(1, 6) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_digest_word(out_data_o);
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_item_t    req;
    int unsigned len;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty message, an ignored empty request, extreme byte values,
    // and a message closed by a request that carries no byte.
    send_message(0, 1'b1);
    req = '{data_byte: 8'hFF, has_byte: 1'b0, last: 1'b0};
    send_request(req);
    send_bytes(8'h00, 8'hFF, 8'h80);
    send_bytes(8'h61, 8'h62, 8'h63);
    req = '{data_byte: 8'hFF, has_byte: 1'b1, last: 1'b0};
    send_request(req);
    req = '{data_byte: 8'h00, has_byte: 1'b0, last: 1'b1};
    send_request(req);

    // Random: one message just short of two blocks first, so a full block is
    // compressed mid-message and the padding lands near the length field, then
    // mostly short messages with noise.
    msg_items = 0;
    msg_count = 0;
    noise_on  = 1'b1;
    send_message($urandom_range(119, 127), 1'($urandom_range(0, 1)));
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_message($urandom_range(1, 5), 1'($urandom_range(0, 1)));
    while (msg_items < RandomItems || msg_count < 6) begin
      if (msg_items >= RandomItems - 20) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(50, 70);
      else len = $urandom_range(0, 12);
      send_message(len, $urandom_range(0, 3) == 0);
    end
    in_valid_i <= 1'b0;

    while (sb.digest_words_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
